// ----- rtl/core/unafg_pkg.sv -----
// unafg_pkg: constants shared by the unsolicited neighbor advertisement frame core
// frame layout, register indexes and widths; no dependencies

package unafg_pkg;

   localparam int FRAME_WORDS = 43;
   localparam int POS_W       = 6;
   localparam int WORD_W      = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSUM_ACC_W  = 21;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [WORD_W-1:0] word_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_MAC   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_UPPER = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LOWER = 2'd2;

   // word positions inside the frame
   localparam pos_type POS_MAC_FIRST  = 6'd3;
   localparam pos_type POS_MAC_LAST   = 6'd5;
   localparam pos_type POS_ADDR_FIRST = 6'd11;
   localparam pos_type POS_ADDR_LAST  = 6'd18;
   localparam pos_type POS_CSUM       = 6'd28;
   localparam pos_type POS_LAST       = pos_type'(FRAME_WORDS - 1);

   // fixed frame words
   localparam word_type W_DST_MAC_HI  = 16'h3333;
   localparam word_type W_DST_MAC_LO  = 16'h0001;
   localparam word_type W_ETHERTYPE   = 16'h86dd;
   localparam word_type W_IP_VERSION  = 16'h6000;
   localparam word_type W_PAYLOAD_LEN = 16'h0020;
   localparam word_type W_NXT_HOP     = 16'h3aff;
   localparam word_type W_ALL_NODES   = 16'hff02;
   localparam word_type W_NODES_LOW   = 16'h0001;
   localparam word_type W_NA_TYPE     = 16'h8800;
   localparam word_type W_NA_FLAGS    = 16'h2000;
   localparam word_type W_OPT_TLLA    = 16'h0201;
   localparam word_type W_NEXT_HDR    = 16'h003a;

   // unfolded sum of every fixed word that the checksum covers
   localparam logic [CSUM_ACC_W-1:0] CSUM_INIT = CSUM_ACC_W'(
      32'(W_ALL_NODES) + 32'(W_NODES_LOW) + 32'(W_PAYLOAD_LEN) + 32'(W_NEXT_HDR)
      + 32'(W_NA_TYPE) + 32'(W_NA_FLAGS) + 32'(W_OPT_TLLA));

endpackage

// ----- rtl/core/unsolicited_na_frame_generator_core.sv -----
// unsolicited_na_frame_generator_core: emits unsolicited ipv6 neighbor advertisement frames
// depends on unafg_pkg
//
// usage: a word on the req_ channel with req_send_request high starts one 86-byte ethernet
// frame, sent on the rsp_ channel as 43 big-endian 16-bit words; rsp_last_word marks the
// final word. a request word with req_send_request low is taken and produces nothing.
// csr_ writes set the source mac and the two halves of the advertised address; the user must
// see that they are only written while no frame is in flight; the block does not enforce it.
// after a request is taken the active flag and word counter are set, and the first word then
// loads into the output register once it is free. throughput: one word per cycle while the
// receiver does not stall; the next request is taken in the cycle that the last word of the
// current frame loads into the output register, so unstalled frames follow with no gap.
// the icmpv6 checksum is accumulated from the address and mac words as they go out and
// is folded when word 28 is formed.
// when the receiver stalls the output register holds its word and the counter waits.
// reset (synchronous) clears the active flag, counter, output valid and csr registers to zero.

module unsolicited_na_frame_generator_core
   import unafg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_send_request,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_W-1:0]      rsp_frame_word,
   output logic                   rsp_last_word,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [47:0]           source_mac_ff;
   logic [63:0]           target_upper_ff;
   logic [63:0]           target_lower_ff;

   logic                  active_ff, active_in;
   pos_type               pos_ff, pos_in;
   logic [CSUM_ACC_W-1:0] acc_ff, acc_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              rsp_word_ff, rsp_word_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  advance;
   logic                  req_take;
   word_type              word;
   logic [16:0]           fold1;
   word_type              fold2;

   assign advance   = active_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !active_ff || (advance && (pos_ff == POS_LAST));
   assign req_take  = req_valid && req_ready;

   // end-around fold of the accumulated sum
   assign fold1 = 17'(acc_ff[15:0]) + 17'(acc_ff[CSUM_ACC_W-1:16]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);

   always_comb begin
      case (pos_ff)
         6'd0:  word = W_DST_MAC_HI;
         6'd2:  word = W_DST_MAC_LO;
         6'd3:  word = source_mac_ff[47:32];
         6'd4:  word = source_mac_ff[31:16];
         6'd5:  word = source_mac_ff[15:0];
         6'd6:  word = W_ETHERTYPE;
         6'd7:  word = W_IP_VERSION;
         6'd9:  word = W_PAYLOAD_LEN;
         6'd10: word = W_NXT_HOP;
         6'd11, 6'd31: word = target_upper_ff[63:48];
         6'd12, 6'd32: word = target_upper_ff[47:32];
         6'd13, 6'd33: word = target_upper_ff[31:16];
         6'd14, 6'd34: word = target_upper_ff[15:0];
         6'd15, 6'd35: word = target_lower_ff[63:48];
         6'd16, 6'd36: word = target_lower_ff[47:32];
         6'd17, 6'd37: word = target_lower_ff[31:16];
         6'd18, 6'd38: word = target_lower_ff[15:0];
         6'd19: word = W_ALL_NODES;
         6'd26: word = W_NODES_LOW;
         6'd27: word = W_NA_TYPE;
         6'd28: word = ~fold2;
         6'd29: word = W_NA_FLAGS;
         6'd39: word = W_OPT_TLLA;
         6'd40: word = source_mac_ff[47:32];
         6'd41: word = source_mac_ff[31:16];
         6'd42: word = source_mac_ff[15:0];
         default: word = '0;
      endcase
   end

   always_comb begin
      active_in    = active_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = word;
         rsp_last_in  = (pos_ff == POS_LAST);
         pos_in       = pos_ff + 6'd1;
         // mac words count once, address words twice (source and target)
         if (pos_ff >= POS_MAC_FIRST && pos_ff <= POS_MAC_LAST) begin
            acc_in = acc_ff + CSUM_ACC_W'(word);
         end else if (pos_ff >= POS_ADDR_FIRST && pos_ff <= POS_ADDR_LAST) begin
            acc_in = acc_ff + CSUM_ACC_W'({word, 1'b0});
         end
         if (pos_ff == POS_LAST) begin
            active_in = 1'b0;
         end
      end

      if (req_take && req_send_request) begin
         active_in = 1'b1;
         pos_in    = '0;
         acc_in    = CSUM_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         pos_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         source_mac_ff   <= '0;
         target_upper_ff <= '0;
         target_lower_ff <= '0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SOURCE_MAC:   source_mac_ff   <= csr_write_data[47:0];
               CSR_TARGET_UPPER: target_upper_ff <= csr_write_data;
               CSR_TARGET_LOWER: target_lower_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_word = rsp_word_ff;
   assign rsp_last_word  = rsp_last_ff;

endmodule
